// File: rtl/core/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types, constants and weight tables of the wavelet signature scorer.
// ----------------------------------------------------------------------------
package wsm_pkg;

   localparam int NUM_CHANNELS          = 3;
   localparam int COEFS_PER_CHANNEL_DEF = 15;

   localparam int CHANNEL_W = 2;
   localparam int SLOT_W    = 4;
   localparam int VALUE_W   = 17;
   localparam int ID_W      = 20;
   localparam int SCORE_W   = 27;
   localparam int SUM_W     = 32;

   localparam logic signed [SUM_W-1:0]   SCORE_MIN    = -32'sd40000000;
   localparam logic signed [SUM_W-1:0]   SCORE_MAX    = 32'sd3000000;
   localparam logic signed [SCORE_W-1:0] THRESH_RESET = -27'sd306000;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_SCORE = 1'b1;

   localparam logic [CHANNEL_W-1:0] CH_Y = 2'd0;
   localparam logic [CHANNEL_W-1:0] CH_I = 2'd1;
   localparam logic [CHANNEL_W-1:0] CH_Q = 2'd2;

   typedef struct packed {
      logic                      valid;
      logic                      cmd;
      logic [CHANNEL_W-1:0]      channel;
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic [ID_W-1:0]           candidate_id;
      logic                      found;
   } stage_type;

   // average weights, 1/255 units scaled by 25500
   function automatic logic [11:0] avg_weight(input logic [CHANNEL_W-1:0] ch);
      logic [11:0] w;
      case (ch)
         CH_Y:    w = 12'd500;
         CH_I:    w = 12'd1921;
         default: w = 12'd3437;
      endcase
      return w;
   endfunction

   function automatic logic [19:0] coef_weight(input logic [2:0] k,
                                               input logic [CHANNEL_W-1:0] ch);
      logic [19:0] w;
      case (k)
         3'd0: begin
            case (ch)
               CH_Y:    w = 20'd127500;
               CH_I:    w = 20'd489855;
               default: w = 20'd876435;
            endcase
         end
         3'd1: begin
            case (ch)
               CH_Y:    w = 20'd21165;
               CH_I:    w = 20'd32130;
               default: w = 20'd9180;
            endcase
         end
         3'd2: begin
            case (ch)
               CH_Y:    w = 20'd25755;
               CH_I:    w = 20'd11220;
               default: w = 20'd11475;
            endcase
         end
         3'd3: begin
            case (ch)
               CH_Y:    w = 20'd13260;
               CH_I:    w = 20'd13515;
               default: w = 20'd3570;
            endcase
         end
         3'd4: begin
            case (ch)
               CH_Y:    w = 20'd11985;
               CH_I:    w = 20'd7140;
               default: w = 20'd4590;
            endcase
         end
         default: begin
            case (ch)
               CH_Y:    w = 20'd7650;
               CH_I:    w = 20'd3570;
               default: w = 20'd6885;
            endcase
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/wsm_intf.sv
// ----------------------------------------------------------------------------
// wsm_req_if / wsm_rsp_if
// Valid/ready channels for signature elements and score results.
// ----------------------------------------------------------------------------
interface wsm_req_if
   import wsm_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [CHANNEL_W-1:0]      channel;
   logic [SLOT_W-1:0]         slot;
   logic signed [VALUE_W-1:0] value;
   logic                      last;
   logic [ID_W-1:0]           candidate_id;

   modport source (output valid, cmd, channel, slot, value, last, candidate_id,
                   input ready);
   modport sink   (input valid, cmd, channel, slot, value, last, candidate_id,
                   output ready);
endinterface

interface wsm_rsp_if
   import wsm_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [ID_W-1:0]           result_id;
   logic signed [SCORE_W-1:0] score;
   logic                      is_match;

   modport source (output valid, result_id, score, is_match, input ready);
   modport sink   (input valid, result_id, score, is_match, output ready);
endinterface

// File: rtl/core/wsm_coef_cell.sv
// ----------------------------------------------------------------------------
// wsm_coef_cell
// One list position of the reference: holds that coefficient for all three
// channels, loads it or matches it as a transaction passes by.
// ----------------------------------------------------------------------------
module wsm_coef_cell
   import wsm_pkg::*;
#(
   parameter int COEFS_PER_CHANNEL = COEFS_PER_CHANNEL_DEF,
   parameter int CELL_IDX          = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  stage_type link_in,
   output stage_type link_out
);

   logic signed [VALUE_W-1:0] ref_ff [NUM_CHANNELS];
   logic signed [VALUE_W-1:0] ref_sel;
   stage_type                 link_ff;
   stage_type                 link_in_d;
   logic                      ch_ok;
   logic                      slot_hit;
   logic                      slot_coef;
   logic                      wr;
   logic                      hit;

   always_comb begin
      case (link_in.channel)
         CH_Y:    ref_sel = ref_ff[0];
         CH_I:    ref_sel = ref_ff[1];
         CH_Q:    ref_sel = ref_ff[2];
         default: ref_sel = '0;
      endcase
   end

   assign ch_ok     = (link_in.channel != 2'd3);
   assign slot_hit  = (int'(link_in.slot) == CELL_IDX + 1);
   assign slot_coef = (link_in.slot != '0) && (int'(link_in.slot) <= COEFS_PER_CHANNEL);
   assign wr        = en && link_in.valid && (link_in.cmd == CMD_LOAD) && ch_ok && slot_hit;
   assign hit       = link_in.valid && (link_in.cmd == CMD_SCORE) && ch_ok && slot_coef
                      && (link_in.value != '0) && (ref_sel == link_in.value);

   always_comb begin
      link_in_d       = link_in;
      link_in_d.found = link_in.found | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            ref_ff[c] <= '0;
         end
      end else if (wr) begin
         case (link_in.channel)
            CH_Y:    ref_ff[0] <= link_in.value;
            CH_I:    ref_ff[1] <= link_in.value;
            default: ref_ff[2] <= link_in.value;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else if (en) begin
         link_ff <= link_in_d;
      end
   end

   assign link_out = link_ff;

endmodule

// File: rtl/core/wsm_score_stage.sv
// ----------------------------------------------------------------------------
// wsm_score_stage
// End of the chain: reference averages, score accumulator, threshold and
// the result register.
// ----------------------------------------------------------------------------
module wsm_score_stage
   import wsm_pkg::*;
#(
   parameter int COEFS_PER_CHANNEL = COEFS_PER_CHANNEL_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  stage_type                 link_in,
   input  logic                      csr_we,
   input  logic signed [SCORE_W-1:0] csr_wdata,
   output logic                      advance,
   wsm_rsp_if.source                 rsp
);

   logic signed [VALUE_W-1:0] avg_ff [NUM_CHANNELS];
   logic signed [SCORE_W-1:0] acc_ff;
   logic signed [SCORE_W-1:0] acc_in;
   logic signed [SCORE_W-1:0] thr_ff;
   logic                      out_valid_ff;
   logic [ID_W-1:0]           out_id_ff;
   logic signed [SCORE_W-1:0] out_score_ff;
   logic                      out_match_ff;

   logic signed [VALUE_W-1:0] avg_sel;
   logic                      usable;
   logic                      emit;
   logic                      take;
   logic signed [VALUE_W:0]   diff;
   logic [VALUE_W:0]          diff_mag;
   logic [VALUE_W+11:0]       avg_prod;
   logic [VALUE_W-1:0]        coef_mag;
   logic [7:0]                lo_b;
   logic [7:0]                hi_b;
   logic [7:0]                big_b;
   logic [2:0]                k;
   logic signed [SUM_W-1:0]   delta;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SCORE_W-1:0] sum_sat;

   always_comb begin
      case (link_in.channel)
         CH_Y:    avg_sel = avg_ff[0];
         CH_I:    avg_sel = avg_ff[1];
         CH_Q:    avg_sel = avg_ff[2];
         default: avg_sel = '0;
      endcase
   end

   assign usable = (link_in.channel != 2'd3) && (int'(link_in.slot) <= COEFS_PER_CHANNEL);
   assign emit   = link_in.valid && (link_in.cmd == CMD_SCORE) && link_in.last;
   assign advance = !out_valid_ff || rsp.ready || !emit;
   assign take   = advance && link_in.valid;

   always_comb begin
      diff     = {link_in.value[VALUE_W-1], link_in.value} - {avg_sel[VALUE_W-1], avg_sel};
      diff_mag = diff[VALUE_W] ? VALUE_W'(1) + (VALUE_W+1)'(~diff) : diff;
      avg_prod = diff_mag * avg_weight(link_in.channel);
      coef_mag = link_in.value[VALUE_W-1] ? VALUE_W'(-link_in.value)
                                          : VALUE_W'(link_in.value);
      lo_b     = coef_mag[7:0];
      hi_b     = coef_mag[15:8];
      big_b    = (hi_b > lo_b) ? hi_b : lo_b;
      k        = (big_b > 8'd5) ? 3'd5 : big_b[2:0];

      delta = '0;
      if (link_in.cmd == CMD_SCORE && usable) begin
         if (link_in.slot == '0) begin
            delta = SUM_W'(avg_prod);
         end else if (link_in.found) begin
            delta = -SUM_W'(coef_weight(k, link_in.channel));
         end
      end
      sum = SUM_W'(acc_ff) + delta;
      if (sum < SCORE_MIN) begin
         sum_sat = SCORE_W'(SCORE_MIN);
      end else if (sum > SCORE_MAX) begin
         sum_sat = SCORE_W'(SCORE_MAX);
      end else begin
         sum_sat = SCORE_W'(sum);
      end
      acc_in = acc_ff;
      if (take && link_in.cmd == CMD_SCORE) begin
         acc_in = link_in.last ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            avg_ff[c] <= '0;
         end
      end else if (take && link_in.cmd == CMD_LOAD && usable && link_in.slot == '0) begin
         case (link_in.channel)
            CH_Y:    avg_ff[0] <= link_in.value;
            CH_I:    avg_ff[1] <= link_in.value;
            default: avg_ff[2] <= link_in.value;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         thr_ff       <= THRESH_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (take && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         out_id_ff    <= link_in.candidate_id;
         out_score_ff <= sum_sat;
         out_match_ff <= (sum_sat < thr_ff);
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.result_id = out_id_ff;
   assign rsp.score     = out_score_ff;
   assign rsp.is_match  = out_match_ff;

   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(acc_ff) >= SCORE_MIN) && (SUM_W'(acc_ff) <= SCORE_MAX))
      else $error("accumulator outside score range");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (take && emit) |=> (acc_ff == '0))
      else $error("accumulator not cleared after result");

   a_emit_loads_out: assert property (@(posedge clock) disable iff (reset)
      (take && emit) |=> out_valid_ff)
      else $error("result not registered");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !advance |-> (out_valid_ff && !rsp.ready && emit))
      else $error("chain stalled without a pending result");

endmodule

// File: rtl/core/wavelet_signature_match_score_unit.sv
// ----------------------------------------------------------------------------
// wavelet_signature_match_score_unit
// Wavelet signature similarity scorer built as a chain of reference cells.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | cmd channel slot value last candidate_id
//   rsp     | out | valid/ready   | result_id score is_match
//   csr     | in  | we            | match_threshold
//
// One transaction per cycle while the chain is not held; a transaction walks one
// coefficient cell per cycle, then its result is registered. Synchronous reset
// clears the reference, the accumulator and sets the threshold to -306000. The
// chain holds only while a result is due at its end, the result register is
// still full and rsp.ready is low.
// ----------------------------------------------------------------------------
module wavelet_signature_match_score_unit
   import wsm_pkg::*;
#(
   parameter int COEFS_PER_CHANNEL = COEFS_PER_CHANNEL_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   wsm_req_if.sink                   req,
   wsm_rsp_if.source                 rsp,
   input  logic                      csr_we,
   input  logic signed [SCORE_W-1:0] csr_wdata
);

   stage_type link [COEFS_PER_CHANNEL+1];
   logic      advance;

   always_comb begin
      link[0].valid        = req.valid;
      link[0].cmd          = req.cmd;
      link[0].channel      = req.channel;
      link[0].slot         = req.slot;
      link[0].value        = req.value;
      link[0].last         = req.last;
      link[0].candidate_id = req.candidate_id;
      link[0].found        = 1'b0;
   end

   assign req.ready = advance;

   for (genvar i = 0; i < COEFS_PER_CHANNEL; i++) begin : g_cell
      wsm_coef_cell #(
         .COEFS_PER_CHANNEL(COEFS_PER_CHANNEL),
         .CELL_IDX         (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (advance),
         .link_in (link[i]),
         .link_out(link[i+1])
      );
   end

   wsm_score_stage #(
      .COEFS_PER_CHANNEL(COEFS_PER_CHANNEL)
   ) u_score (
      .clock    (clock),
      .reset    (reset),
      .link_in  (link[COEFS_PER_CHANNEL]),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .advance  (advance),
      .rsp      (rsp)
   );

endmodule
